[src/gprp_pkg.sv]
// ----------------------------------------------------------------------------
// gprp_pkg
// Shared widths, register map, reset values and divide-by-ten constants for
// the grid point rotate/project core.
// ----------------------------------------------------------------------------
package gprp_pkg;

    // input item fields
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int HGT_W     = 16;
    localparam int COLOR_W   = 24;
    localparam int S_TDATA_W = 64;

    // result item fields
    localparam int COORD_W   = 32;
    localparam int M_TDATA_W = 136;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam int ZOOM_W   = 10;
    localparam int GAIN_W   = 9;
    localparam int PAIR_W   = 32;
    localparam int TRIG_W   = 16;
    localparam int CENTER_W = 48;
    localparam int OFFSET_W = 21;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ZOOM            = 3'd0,
        REG_ELEVATION_GAIN  = 3'd1,
        REG_ROT_X_PAIR      = 3'd2,
        REG_ROT_Y_PAIR      = 3'd3,
        REG_ROT_Z_PAIR      = 3'd4,
        REG_ROTATION_CENTER = 3'd5,
        REG_OFFSET_X        = 3'd6,
        REG_OFFSET_Y        = 3'd7
    } cfg_reg_t;

    localparam logic [ZOOM_W-1:0]          ZOOM_RESET     = 10'd20;
    localparam logic signed [GAIN_W-1:0]   GAIN_RESET     = 9'sd1;
    localparam logic [PAIR_W-1:0]          ROT_PAIR_RESET = 32'h4000_0000;
    localparam logic [CENTER_W-1:0]        CENTER_RESET   = '0;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET   = '0;

    // height product magnitude: |height| (16 bits) times |gain*zoom| (18 bits)
    localparam int GZ_W       = 20;
    localparam int GZ_MAG_W   = 18;
    localparam int DIV_N_W    = 34;
    localparam int DIV_HALF_W = 17;

    // floor(n/10) = (n * ceil(2^38/10)) >> 38, exact for n < 2^34
    localparam int                 DIV10_MUL_W = 35;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 35'd27487790695;
    localparam int                 DIV10_SHIFT = 38;
    localparam int                 DIV_PP_W    = DIV_HALF_W + DIV10_MUL_W;
    localparam int                 DIV_SUM_W   = DIV_PP_W + DIV_HALF_W;
    localparam int                 QUOT_W      = DIV_SUM_W - DIV10_SHIFT;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

endpackage

[src/grid_point_rotate_project_core.sv]
// Throughput: one point per cycle; thirteen register stages advance together
// and stall as one when the output register holds a result not yet taken.
// s_tready follows m_tready combinationally through that common stage enable.
// Reset (aresetn low at a clock edge) empties the pipeline and returns all
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
// grid_point_rotate_project_core
// Scales a height-map grid point, rotates it about z, x and y around a
// configured center with fixed-point cosine/sine pairs, and adds the pan.
// ----------------------------------------------------------------------------
module grid_point_rotate_project_core #(
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // configuration writes
    input  logic                               cfg_we,
    input  logic [gprp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gprp_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // points in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [9:0] column, [19:10] row, [35:20] height, [59:36] color, [63:60] zero
    input  logic [gprp_pkg::S_TDATA_W-1:0]     s_tdata,

    // projected points out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] screen_x, [63:32] screen_y, [95:64] depth, [111:96] raw_height,
    // [135:112] point_color
    output logic [gprp_pkg::M_TDATA_W-1:0]     m_tdata
);
    import gprp_pkg::*;

    localparam int F          = TRIG_FRACTION_BITS;
    localparam int NUM_STAGES = 13;
    localparam int AB_W       = 22;                 // scaled column/row minus center
    localparam int PZ_W       = AB_W + TRIG_W;      // z rotation products
    localparam int D_W        = COORD_W + 1;        // coordinate minus center
    localparam int PD_W       = D_W + TRIG_W;       // x and y rotation products
    localparam int ACC_BASE_W = (TRIG_W + F > PD_W) ? TRIG_W + F : PD_W;
    localparam int ACC_W      = ACC_BASE_W + 2;

    typedef logic signed [ACC_W-1:0] acc_t;

    // divide by 2^F truncating toward zero, then clamp to 32 bits
    function automatic coord_t trunc_sat(input acc_t acc);
        acc_t   q;
        coord_t res;
        q = acc >>> F;
        if (acc[ACC_W-1] && (acc[F-1:0] != '0)) begin
            q = q + ACC_W'(1);
        end
        if ((q[ACC_W-1:COORD_W-1] == '0) || (q[ACC_W-1:COORD_W-1] == '1)) begin
            res = q[COORD_W-1:0];
        end else begin
            res = q[ACC_W-1] ? COORD_MIN : COORD_MAX;
        end
        return res;
    endfunction

    function automatic coord_t sat33(input logic signed [D_W-1:0] v);
        coord_t res;
        if (v[D_W-1] == v[D_W-2]) begin
            res = v[COORD_W-1:0];
        end else begin
            res = v[D_W-1] ? COORD_MIN : COORD_MAX;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ZOOM_W-1:0]          zoom_reg;
    logic signed [GAIN_W-1:0]   gain_reg;
    logic [PAIR_W-1:0]          rot_x_reg;
    logic [PAIR_W-1:0]          rot_y_reg;
    logic [PAIR_W-1:0]          rot_z_reg;
    logic [CENTER_W-1:0]        center_reg;
    logic signed [OFFSET_W-1:0] offset_x_reg;
    logic signed [OFFSET_W-1:0] offset_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg     <= ZOOM_RESET;
            gain_reg     <= GAIN_RESET;
            rot_x_reg    <= ROT_PAIR_RESET;
            rot_y_reg    <= ROT_PAIR_RESET;
            rot_z_reg    <= ROT_PAIR_RESET;
            center_reg   <= CENTER_RESET;
            offset_x_reg <= OFFSET_RESET;
            offset_y_reg <= OFFSET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ZOOM:            zoom_reg     <= cfg_wdata[ZOOM_W-1:0];
                REG_ELEVATION_GAIN:  gain_reg     <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_ROT_X_PAIR:      rot_x_reg    <= cfg_wdata[PAIR_W-1:0];
                REG_ROT_Y_PAIR:      rot_y_reg    <= cfg_wdata[PAIR_W-1:0];
                REG_ROT_Z_PAIR:      rot_z_reg    <= cfg_wdata[PAIR_W-1:0];
                REG_ROTATION_CENTER: center_reg   <= cfg_wdata[CENTER_W-1:0];
                REG_OFFSET_X:        offset_x_reg <= $signed(cfg_wdata[OFFSET_W-1:0]);
                REG_OFFSET_Y:        offset_y_reg <= $signed(cfg_wdata[OFFSET_W-1:0]);
            endcase
        end
    end

    trig_t cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
    trig_t ctr_x, ctr_y, ctr_z;

    assign cos_x = $signed(rot_x_reg[31:16]);
    assign sin_x = $signed(rot_x_reg[15:0]);
    assign cos_y = $signed(rot_y_reg[31:16]);
    assign sin_y = $signed(rot_y_reg[15:0]);
    assign cos_z = $signed(rot_z_reg[31:16]);
    assign sin_z = $signed(rot_z_reg[15:0]);
    assign ctr_x = $signed(center_reg[47:32]);
    assign ctr_y = $signed(center_reg[31:16]);
    assign ctr_z = $signed(center_reg[15:0]);

    // ------------------------------------------------------------------
    // pipeline control: all stages advance together
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic                  adv;

    assign adv      = !valid_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    // height and color ride along unchanged
    logic [HGT_W-1:0]   hgt_pipe_reg   [NUM_STAGES];
    logic [COLOR_W-1:0] color_pipe_reg [NUM_STAGES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            hgt_pipe_reg[0]   <= s_tdata[35:20];
            color_pipe_reg[0] <= s_tdata[59:36];
            for (int i = 1; i < NUM_STAGES; i++) begin
                hgt_pipe_reg[i]   <= hgt_pipe_reg[i-1];
                color_pipe_reg[i] <= color_pipe_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: grid scaling, gain*zoom
    // ------------------------------------------------------------------
    logic [COL_W-1:0]               col_in;
    logic [ROW_W-1:0]               row_in;
    logic [COL_W+ZOOM_W-1:0]        col_zoom;
    logic [ROW_W+ZOOM_W-1:0]        row_zoom;
    logic signed [GZ_W-1:0]         gain_zoom;
    logic signed [AB_W-1:0]         s1_a_reg, s1_b_reg;
    logic signed [GZ_W-1:0]         s1_gz_reg;

    assign col_in    = s_tdata[9:0];
    assign row_in    = s_tdata[19:10];
    assign col_zoom  = col_in * zoom_reg;
    assign row_zoom  = row_in * zoom_reg;
    assign gain_zoom = gain_reg * $signed({1'b0, zoom_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_a_reg  <= $signed({2'b00, col_zoom}) - AB_W'(ctr_x);
            s1_b_reg  <= $signed({2'b00, row_zoom}) - AB_W'(ctr_y);
            s1_gz_reg <= gain_zoom;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: z rotation products, height magnitude product
    // ------------------------------------------------------------------
    logic [HGT_W-1:0]        hgt_mag;
    logic [GZ_W-1:0]         gz_mag_full;
    logic [GZ_MAG_W-1:0]     gz_mag;
    logic signed [PZ_W-1:0]  s2_p_ac_reg, s2_p_bs_reg, s2_p_bc_reg, s2_p_as_reg;
    logic [DIV_N_W-1:0]      s2_n_reg;
    logic                    s2_neg_reg;

    assign hgt_mag     = hgt_pipe_reg[0][HGT_W-1] ? (~hgt_pipe_reg[0] + HGT_W'(1))
                                                  : hgt_pipe_reg[0];
    assign gz_mag_full = s1_gz_reg[GZ_W-1] ? GZ_W'(-s1_gz_reg) : GZ_W'(s1_gz_reg);
    assign gz_mag      = gz_mag_full[GZ_MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_p_ac_reg <= s1_a_reg * cos_z;
            s2_p_bs_reg <= s1_b_reg * sin_z;
            s2_p_bc_reg <= s1_b_reg * cos_z;
            s2_p_as_reg <= s1_a_reg * sin_z;
            s2_n_reg    <= hgt_mag * gz_mag;
            s2_neg_reg  <= hgt_pipe_reg[0][HGT_W-1] ^ s1_gz_reg[GZ_W-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: z rotation sums, reciprocal partial products
    // ------------------------------------------------------------------
    acc_t                s3_acc_x_reg, s3_acc_y_reg;
    logic [DIV_PP_W-1:0] s3_pp_hi_reg, s3_pp_lo_reg;
    logic                s3_neg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_acc_x_reg <= (ACC_W'(ctr_x) <<< F) + ACC_W'(s2_p_ac_reg)
                            - ACC_W'(s2_p_bs_reg);
            s3_acc_y_reg <= (ACC_W'(ctr_y) <<< F) + ACC_W'(s2_p_bc_reg)
                            + ACC_W'(s2_p_as_reg);
            s3_pp_hi_reg <= s2_n_reg[DIV_N_W-1:DIV_HALF_W] * DIV10_MUL;
            s3_pp_lo_reg <= s2_n_reg[DIV_HALF_W-1:0] * DIV10_MUL;
            s3_neg_reg   <= s2_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: round z rotation, finish divide by ten
    // ------------------------------------------------------------------
    logic [DIV_SUM_W-1:0] div_sum;
    coord_t               s4_x1_reg, s4_y1_reg;
    logic [QUOT_W-1:0]    s4_q_reg;
    logic                 s4_neg_reg;

    assign div_sum = {s3_pp_hi_reg, {DIV_HALF_W{1'b0}}} + DIV_SUM_W'(s3_pp_lo_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_x1_reg  <= trunc_sat(s3_acc_x_reg);
            s4_y1_reg  <= trunc_sat(s3_acc_y_reg);
            s4_q_reg   <= div_sum[DIV_SUM_W-1:DIV10_SHIFT];
            s4_neg_reg <= s3_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: recenter for the x rotation
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] h_val;
    logic signed [D_W-1:0] s5_dx_reg, s5_dy_reg, s5_dz_reg;

    assign h_val = s4_neg_reg ? -$signed({{(D_W-QUOT_W){1'b0}}, s4_q_reg})
                              :  $signed({{(D_W-QUOT_W){1'b0}}, s4_q_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_dx_reg <= D_W'(s4_x1_reg) - D_W'(ctr_x);
            s5_dy_reg <= D_W'(s4_y1_reg) - D_W'(ctr_y);
            s5_dz_reg <= h_val - D_W'(ctr_z);
        end
    end

    // ------------------------------------------------------------------
    // stages 6-8: rotation about x
    // ------------------------------------------------------------------
    logic signed [PD_W-1:0] s6_p_ycx_reg, s6_p_zsx_reg, s6_p_ysx_reg, s6_p_zcx_reg;
    logic signed [D_W-1:0]  s6_dx_reg, s7_dx_reg, s8_dx_reg;
    acc_t                   s7_acc_y_reg, s7_acc_z_reg;
    coord_t                 s8_y2_reg, s8_z2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_p_ycx_reg <= s5_dy_reg * cos_x;
            s6_p_zsx_reg <= s5_dz_reg * sin_x;
            s6_p_ysx_reg <= s5_dy_reg * sin_x;
            s6_p_zcx_reg <= s5_dz_reg * cos_x;
            s6_dx_reg    <= s5_dx_reg;

            s7_acc_y_reg <= (ACC_W'(ctr_y) <<< F) + ACC_W'(s6_p_ycx_reg)
                            - ACC_W'(s6_p_zsx_reg);
            s7_acc_z_reg <= (ACC_W'(ctr_z) <<< F) + ACC_W'(s6_p_ysx_reg)
                            + ACC_W'(s6_p_zcx_reg);
            s7_dx_reg    <= s6_dx_reg;

            s8_y2_reg    <= trunc_sat(s7_acc_y_reg);
            s8_z2_reg    <= trunc_sat(s7_acc_z_reg);
            s8_dx_reg    <= s7_dx_reg;
        end
    end

    // ------------------------------------------------------------------
    // stages 9-12: rotation about y
    // ------------------------------------------------------------------
    logic signed [D_W-1:0]  s9_dx_reg, s9_dz_reg;
    coord_t                 s9_y2_reg, s10_y2_reg, s11_y2_reg, s12_y2_reg;
    logic signed [PD_W-1:0] s10_p_xcy_reg, s10_p_zsy_reg, s10_p_xsy_reg, s10_p_zcy_reg;
    acc_t                   s11_acc_x_reg, s11_acc_z_reg;
    coord_t                 s12_x3_reg, s12_z3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s9_dx_reg     <= s8_dx_reg;
            s9_dz_reg     <= D_W'(s8_z2_reg) - D_W'(ctr_z);
            s9_y2_reg     <= s8_y2_reg;

            s10_p_xcy_reg <= s9_dx_reg * cos_y;
            s10_p_zsy_reg <= s9_dz_reg * sin_y;
            s10_p_xsy_reg <= s9_dx_reg * sin_y;
            s10_p_zcy_reg <= s9_dz_reg * cos_y;
            s10_y2_reg    <= s9_y2_reg;

            s11_acc_x_reg <= (ACC_W'(ctr_x) <<< F) + ACC_W'(s10_p_xcy_reg)
                             - ACC_W'(s10_p_zsy_reg);
            s11_acc_z_reg <= (ACC_W'(ctr_z) <<< F) + ACC_W'(s10_p_xsy_reg)
                             + ACC_W'(s10_p_zcy_reg);
            s11_y2_reg    <= s10_y2_reg;

            s12_x3_reg    <= trunc_sat(s11_acc_x_reg);
            s12_z3_reg    <= trunc_sat(s11_acc_z_reg);
            s12_y2_reg    <= s11_y2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 13: pan offsets, output register
    // ------------------------------------------------------------------
    coord_t out_x_reg, out_y_reg, out_depth_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg     <= sat33(D_W'(s12_x3_reg) + D_W'(offset_x_reg));
            out_y_reg     <= sat33(D_W'(s12_y2_reg) + D_W'(offset_y_reg));
            out_depth_reg <= s12_z3_reg;
        end
    end

    assign m_tdata = {color_pipe_reg[NUM_STAGES-1], hgt_pipe_reg[NUM_STAGES-1],
                      out_depth_reg, out_y_reg, out_x_reg};

endmodule
